// ===== rtl/core/fptw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fptw_pkg
// Types, codes and helpers shared by the four-level page table walker.
// ----------------------------------------------------------------------------
package fptw_pkg;

  localparam int VADDR_W    = 48;
  localparam int ADDR_W     = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int INDEX_W    = 9;
  localparam int ENTRY_LSB  = 3;   // log2 of the 8-byte entry size

  localparam logic       OP_REQUEST  = 1'b0;
  localparam logic       OP_RESPONSE = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;
  localparam logic [1:0] KIND_BUSY  = 2'd3;

  localparam logic [1:0] LEVEL_TOP  = 2'd0;
  localparam logic [1:0] LEVEL_LAST = 2'd3;

  typedef struct packed {
    logic                opcode;
    logic [ADDR_W-1:0]   root_table;
    logic [VADDR_W-1:0]  virtual_address;
    logic [ADDR_W-1:0]   read_data;
    logic                read_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [ADDR_W-1:0]   address;
    logic [1:0]          walk_level;
  } out_item_t;

  typedef struct packed {
    logic                valid;
    out_item_t           item;
  } step_res_t;

  typedef struct packed {
    logic                busy;
    logic [1:0]          level;
  } walk_stat_t;

  // Byte offset of the entry for one level: 9-bit index times 8.
  function automatic logic [ADDR_W-1:0] entry_offset(input logic [VADDR_W-1:0] vaddr,
                                                      input logic [1:0] level);
    logic [INDEX_W-1:0] idx;
    unique case (level)
      2'd0:    idx = vaddr[47:39];
      2'd1:    idx = vaddr[38:30];
      2'd2:    idx = vaddr[29:21];
      default: idx = vaddr[20:12];
    endcase
    return {{(ADDR_W-INDEX_W-ENTRY_LSB){1'b0}}, idx, {ENTRY_LSB{1'b0}}};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fptw_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fptw_step
// Walk state and per-word next-state and result logic.
// ----------------------------------------------------------------------------
module fptw_step #(
  parameter int ENTRY_ADDR_BITS = 40
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_fire,
  input  fptw_pkg::in_item_t   in_item,
  output fptw_pkg::step_res_t  res,
  output fptw_pkg::walk_stat_t stat
);
  import fptw_pkg::*;

  logic               busy_r,  busy_nxt;
  logic [1:0]         level_r, level_nxt;
  logic [VADDR_W-1:0] vaddr_r, vaddr_nxt;

  logic [ADDR_W-1:0]  root_base;
  logic [ADDR_W-1:0]  entry_base;
  logic [1:0]         level_inc;

  always_comb begin
    root_base = {in_item.root_table[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    entry_base = '0;
    entry_base[ENTRY_ADDR_BITS-1:PAGE_SHIFT] =
      in_item.read_data[ENTRY_ADDR_BITS-1:PAGE_SHIFT];
    level_inc = level_r + 2'd1;
  end

  always_comb begin
    busy_nxt  = busy_r;
    level_nxt = level_r;
    vaddr_nxt = vaddr_r;
    res       = '0;
    if (in_item.opcode == OP_REQUEST) begin
      res.valid = 1'b1;
      if (busy_r) begin
        res.item.kind       = KIND_BUSY;
        res.item.walk_level = level_r;
      end else begin
        busy_nxt  = 1'b1;
        level_nxt = LEVEL_TOP;
        vaddr_nxt = in_item.virtual_address;
        res.item.kind       = KIND_READ;
        res.item.address    = root_base + entry_offset(in_item.virtual_address, LEVEL_TOP);
        res.item.walk_level = LEVEL_TOP;
      end
    end else if (busy_r) begin
      res.valid = 1'b1;
      priority if (!in_item.read_ok) begin
        res.item.kind       = KIND_FAULT;
        res.item.walk_level = level_r;
        busy_nxt  = 1'b0;
        level_nxt = LEVEL_TOP;
      end else if (level_r == LEVEL_LAST) begin
        res.item.kind       = KIND_DONE;
        res.item.address    = entry_base +
                              {{(ADDR_W-PAGE_SHIFT){1'b0}}, vaddr_r[PAGE_SHIFT-1:0]};
        res.item.walk_level = LEVEL_LAST;
        busy_nxt  = 1'b0;
        level_nxt = LEVEL_TOP;
      end else begin
        res.item.kind       = KIND_READ;
        res.item.address    = entry_base + entry_offset(vaddr_r, level_inc);
        res.item.walk_level = level_inc;
        level_nxt = level_inc;
      end
    end
    // response while idle: drop
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      level_r <= LEVEL_TOP;
      vaddr_r <= '0;
    end else if (in_fire) begin
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
      vaddr_r <= vaddr_nxt;
    end
  end

  assign stat.busy  = busy_r;
  assign stat.level = level_r;

endmodule
`default_nettype wire

// ===== rtl/core/fptw_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fptw_out_stage
// Result register; takes a new word when empty or in the cycle the held one drains.
// ----------------------------------------------------------------------------
module fptw_out_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  fptw_pkg::step_res_t  res,
  output logic                 out_valid,
  input  wire                  out_ready,
  output fptw_pkg::out_item_t  out_data
);
  import fptw_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      load;

  assign in_ready = !out_valid_r || out_ready;
  assign load     = in_valid && in_ready && res.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/four_level_page_table_walker.sv =====
`default_nettype none
// A result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; a word is taken whenever the result register
// is empty or drains in the same cycle.
// Responses that arrive while idle are dropped and give no result word.
// Reset (rst_n low, synchronous) leaves the walker idle at level 0 with the
// result register empty.
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Translates a 48-bit virtual address through four levels of 64-bit entries.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
  parameter int ENTRY_ADDR_BITS = 40
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  fptw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output fptw_pkg::out_item_t out_data
);
  import fptw_pkg::*;

  step_res_t  res;
  walk_stat_t stat;
  logic       in_fire;

  assign in_fire = in_valid && in_ready;

  fptw_step #(
    .ENTRY_ADDR_BITS(ENTRY_ADDR_BITS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_item(in_data),
    .res    (res),
    .stat   (stat)
  );

  fptw_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .res      (res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  a_idle_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.opcode == OP_REQUEST && !stat.busy
      |=> stat.busy && stat.level == LEVEL_TOP && out_valid
          && out_data.kind == KIND_READ)
    else $error("request while idle did not start a walk");

  a_idle_response_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.opcode == OP_RESPONSE && !stat.busy
      |=> !stat.busy && (out_valid == $past(out_valid && !out_ready)))
    else $error("response while idle changed state or made a result");

  a_done_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.opcode == OP_RESPONSE && stat.busy && in_data.read_ok
      && stat.level == LEVEL_LAST
      |=> !stat.busy && out_data.kind == KIND_DONE && out_data.walk_level == LEVEL_LAST)
    else $error("walk did not finish after the last level");

  a_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_FAULT || out_data.kind == KIND_BUSY)
      |-> out_data.address == '0)
    else $error("fault or busy word carries an address");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-level page table walker. A directed table
// covers idle responses, rejected requests, faults at the top and last levels
// and all-ones/all-zero entries. Random walks with faults, busy requests and
// idle noise follow, with random gaps on both channels. Every result word is
// checked against the table's expected word or a behavioral walk model.
// ----------------------------------------------------------------------------
module tb_top;
  import fptw_pkg::*;

  localparam int          ENTRY_BITS = 40;
  localparam logic [63:0] ENTRY_MASK = ((64'd1 << ENTRY_BITS) - 64'd1) & ~64'hFFF;
  localparam int          RAND_WORDS = 1100;
  localparam int          HOLD_AT    = 300;
  localparam int          HOLD_LEN   = 64;
  localparam int          CALM_FROM  = 600;
  localparam int          CALM_TO    = 800;
  localparam int          GAP_PCT    = 25;
  localparam int          LIMIT      = 200000;

  typedef enum {ROW_PREDICT, ROW_GIVEN, ROW_SILENT} row_check_t;

  typedef struct {
    in_item_t   w;
    row_check_t how;
    out_item_t  want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // walk model state
  bit          walking = 1'b0;
  logic [1:0]  wait_lvl = LEVEL_TOP;
  logic [47:0] walk_va = '0;

  out_item_t expected_words[$];
  row_t      plan[$];
  int        n_done = 0;
  int        n_errors = 0;
  int        cycles = 0;

  four_level_page_table_walker #(
    .ENTRY_ADDR_BITS(ENTRY_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] idx_byte_offset(input logic [47:0] va,
                                                  input logic [1:0] lvl);
    logic [47:0] t;
    t = va >> (39 - 9 * int'(lvl));
    return {52'd0, t[8:0], 3'b000};
  endfunction

  // Advance the walk model by one accepted word; return 1 if it yields a result.
  function automatic bit predict_walk(input in_item_t w, output out_item_t r);
    logic [63:0] base;
    r = '0;
    if (w.opcode == OP_REQUEST) begin
      if (walking) begin
        r.kind = KIND_BUSY;
        r.walk_level = wait_lvl;
        return 1'b1;
      end
      walking = 1'b1;
      wait_lvl = LEVEL_TOP;
      walk_va = w.virtual_address;
      r.kind = KIND_READ;
      r.address = {w.root_table[63:12], 12'h000} + idx_byte_offset(walk_va, LEVEL_TOP);
      r.walk_level = LEVEL_TOP;
      return 1'b1;
    end
    if (!walking) return 1'b0;
    if (!w.read_ok) begin
      r.kind = KIND_FAULT;
      r.walk_level = wait_lvl;
      walking = 1'b0;
      wait_lvl = LEVEL_TOP;
      return 1'b1;
    end
    base = w.read_data & ENTRY_MASK;
    if (wait_lvl == LEVEL_LAST) begin
      r.kind = KIND_DONE;
      r.address = base + {52'd0, walk_va[11:0]};
      r.walk_level = LEVEL_LAST;
      walking = 1'b0;
      wait_lvl = LEVEL_TOP;
      return 1'b1;
    end
    wait_lvl = wait_lvl + 2'd1;
    r.kind = KIND_READ;
    r.address = base + idx_byte_offset(walk_va, wait_lvl);
    r.walk_level = wait_lvl;
    return 1'b1;
  endfunction

  function automatic in_item_t req(input logic [63:0] root, input logic [47:0] va);
    in_item_t w;
    w = '0;
    w.opcode = OP_REQUEST;
    w.root_table = root;
    w.virtual_address = va;
    return w;
  endfunction

  function automatic in_item_t rsp(input logic [63:0] data, input logic ok);
    in_item_t w;
    w = '0;
    w.opcode = OP_RESPONSE;
    w.read_data = data;
    w.read_ok = ok;
    return w;
  endfunction

  function automatic row_t given(input in_item_t w, input logic [1:0] k,
                                 input logic [63:0] a, input logic [1:0] l);
    row_t r;
    r.w = w;
    r.how = ROW_GIVEN;
    r.want.kind = k;
    r.want.address = a;
    r.want.walk_level = l;
    return r;
  endfunction

  function automatic row_t pred(input in_item_t w);
    row_t r;
    r.w = w;
    r.how = ROW_PREDICT;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t quiet(input in_item_t w);
    row_t r;
    r.w = w;
    r.how = ROW_SILENT;
    r.want = '0;
    return r;
  endfunction

  function automatic bit take_gap();
    if (n_done >= CALM_FROM && n_done < CALM_TO) return 1'b0;
    return $urandom_range(99) < GAP_PCT;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  // Offer one word and hold it until the walker takes it.
  task automatic send_word(input in_item_t w);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_words.size() == 0) begin
        report($sformatf("result word %h with nothing expected", out_data));
      end else begin
        want = expected_words.pop_front();
        if (out_data.kind !== want.kind)
          report($sformatf("kind got %0d want %0d", out_data.kind, want.kind));
        if (out_data.address !== want.address)
          report($sformatf("address got %h want %h", out_data.address, want.address));
        if (out_data.walk_level !== want.walk_level)
          report($sformatf("walk_level got %0d want %0d", out_data.walk_level,
                           want.walk_level));
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && n_done >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        out_ready <= !take_gap();
        @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t  w;
    out_item_t got;
    bit        has;
    int        n_rand;
    int        roll;

    plan.push_back(quiet(rsp(64'hFFFF_FFFF_FFFF_FFFF, 1'b1)));
    plan.push_back(given(req(64'hFFFF_FFFF_FFFF_FFFF, 48'h0), KIND_READ,
                         64'hFFFF_FFFF_FFFF_F000, LEVEL_TOP));
    plan.push_back(given(req(64'h0, 48'hFFFF_FFFF_FFFF), KIND_BUSY, 64'h0, LEVEL_TOP));
    plan.push_back(given(rsp(64'hFFFF_FFFF_FFFF_FFFF, 1'b0), KIND_FAULT, 64'h0, LEVEL_TOP));
    plan.push_back(given(req(64'h0000_0000_0000_0FFF, 48'hFFFF_FFFF_FFFF), KIND_READ,
                         64'h0000_0000_0000_0FF8, LEVEL_TOP));
    plan.push_back(given(rsp(64'hFFFF_FFFF_FFFF_FFFF, 1'b1), KIND_READ,
                         64'h0000_00FF_FFFF_FFF8, 2'd1));
    plan.push_back(pred(rsp(64'h0000_0000_0000_0FFF, 1'b1)));
    plan.push_back(given(req(64'h1234_5678_9ABC_DEF0, 48'h0), KIND_BUSY, 64'h0, 2'd2));
    plan.push_back(pred(rsp(64'hFFFF_FF00_0000_1000, 1'b1)));
    plan.push_back(given(rsp(64'hFFFF_FFFF_FFFF_FFFF, 1'b1), KIND_DONE,
                         64'h0000_00FF_FFFF_FFFF, LEVEL_LAST));
    plan.push_back(quiet(rsp(64'h0, 1'b0)));
    plan.push_back(given(req(64'hFFFF_FFFF_FFFF_FFFF, 48'hFF80_0000_0000), KIND_READ,
                         64'hFFFF_FFFF_FFFF_FFF8, LEVEL_TOP));
    plan.push_back(given(rsp(64'h0, 1'b1), KIND_READ, 64'h0, 2'd1));
    plan.push_back(given(rsp(64'hFFFF_FFFF_FFFF_FFFF, 1'b0), KIND_FAULT, 64'h0, 2'd1));
    plan.push_back(pred(req(64'h0000_0012_3456_7ABC, 48'h1234_5678_9ABC)));
    plan.push_back(pred(rsp(64'hA5A5_A5A5_A5A5_A5A5, 1'b1)));
    plan.push_back(pred(rsp(64'h5A5A_5A5A_5A5A_5A5A, 1'b1)));
    plan.push_back(pred(rsp(64'h8000_0080_0000_0001, 1'b1)));
    plan.push_back(given(rsp(64'h0, 1'b0), KIND_FAULT, 64'h0, LEVEL_LAST));
    plan.push_back(pred(req(64'h8000_0000_0000_1000, 48'h0000_0000_1FFF)));
    plan.push_back(pred(rsp(64'h0000_0001_0000_0000, 1'b1)));
    plan.push_back(pred(rsp(64'h7FFF_FFFF_FFFF_FFFF, 1'b1)));
    plan.push_back(pred(rsp(64'h0000_0080_0000_0FFF, 1'b1)));
    plan.push_back(pred(rsp(64'h0000_00FF_FFFF_F000, 1'b1)));
    plan.push_back(quiet(rsp(64'h0000_0000_0000_0001, 1'b1)));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      send_word(plan[i].w);
      has = predict_walk(plan[i].w, got);
      if (plan[i].how == ROW_GIVEN) expected_words.push_back(plan[i].want);
      else if (plan[i].how == ROW_PREDICT && has) expected_words.push_back(got);
      if (has) n_done++;
    end

    // Mostly complete walks; a few faults, busy requests and idle noise.
    n_rand = 0;
    while (n_rand < RAND_WORDS) begin
      roll = $urandom_range(99);
      w.root_table      = rand64();
      w.virtual_address = 48'(rand64());
      w.read_ok         = ($urandom_range(99) >= 6);
      case ($urandom_range(9))
        0:       w.read_data = '1;
        1:       w.read_data = '0;
        default: w.read_data = rand64();
      endcase
      if (!walking) w.opcode = (roll < 8) ? OP_RESPONSE : OP_REQUEST;
      else          w.opcode = (roll < 5) ? OP_REQUEST : OP_RESPONSE;
      if (w.opcode == OP_RESPONSE && !walking) w.read_ok = 1'($urandom_range(1));
      send_word(w);
      if (predict_walk(w, got)) begin
        expected_words.push_back(got);
        n_done++;
        n_rand++;
      end
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
